// ===== rtl/core/scx_pkg.sv =====
// scx_pkg: shared types and constants for the sprite chain expander
// holds beat widths, control bit positions, the queued job record and status structs
// no dependencies
package scx_pkg;

    localparam int unsigned IN_W    = 64;   // input beat: six entry fields
    localparam int unsigned OUT_W   = 56;   // output beat: 54 bits of fields, zero padded
    localparam int unsigned POS_W   = 17;
    localparam int unsigned CODE_W  = 14;
    localparam int unsigned COL_W   = 4;
    localparam int unsigned CHAIN_W = 3;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // control byte bit positions
    localparam int unsigned CTL_DISABLE = 7;
    localparam int unsigned CTL_FLIPX   = 5;
    localparam int unsigned CTL_FLIPY   = 4;
    localparam int unsigned CTL_YCHAIN  = 3;

    localparam logic signed [POS_W-1:0] TILE_STEP   = 17'sd16;
    localparam logic signed [POS_W-1:0] WRAP_OFFSET = 17'sd256;

    typedef enum logic [0:0] {
        CFG_FLIPX_EN = 1'b0,
        CFG_WRAP_EN  = 1'b1
    } t_cfg_idx;

    // one classified entry, start position already moved to the far end when reversed
    typedef struct packed {
        logic [CODE_W-1:0]       code;
        logic [COL_W-1:0]        col;
        logic                    flip_x;
        logic                    flip_y;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    ychain;
        logic                    reverse;
        logic [CHAIN_W-1:0]      chain;
        logic                    copy;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/core/scx_front.sv =====
// scx_front: accepts entry beats, holds the configuration registers and classifies entries
// drops disabled entries, pushes enabled ones into the job queue; uses scx_pkg
module scx_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic                       i_cfg_wdata,
    input  logic                       i_tvalid,
    output logic                       o_tready,
    input  logic [scx_pkg::IN_W-1:0]   i_tdata,
    input  scx_pkg::t_qstat            i_qstat,
    output logic                       o_push,
    output scx_pkg::t_job              o_job
);
    import scx_pkg::*;

    logic r_flipx_en;
    logic r_wrap_en;

    logic [15:0]             x_raw;
    logic [15:0]             y_raw;
    logic [7:0]              ctrl;
    logic [7:0]              tile_lo;
    logic [7:0]              tile_hi;
    logic [7:0]              colour;
    logic                    fx;
    logic                    fy;
    logic                    ychain;
    logic [CHAIN_W-1:0]      chain;
    logic signed [POS_W-1:0] x_s;
    logic signed [POS_W-1:0] y_s;
    logic signed [POS_W-1:0] far_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flipx_en <= 1'b1;
            r_wrap_en  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FLIPX_EN: r_flipx_en <= i_cfg_wdata;
                CFG_WRAP_EN:  r_wrap_en  <= i_cfg_wdata;
                default:      r_flipx_en <= r_flipx_en;
            endcase
        end
    end

    always_comb begin
        x_raw   = i_tdata[15:0];
        y_raw   = i_tdata[31:16];
        ctrl    = i_tdata[39:32];
        tile_lo = i_tdata[47:40];
        tile_hi = i_tdata[55:48];
        colour  = i_tdata[63:56];

        fx      = r_flipx_en & ctrl[CTL_FLIPX];
        fy      = ctrl[CTL_FLIPY];
        ychain  = ctrl[CTL_YCHAIN];
        chain   = ctrl[CHAIN_W-1:0];
        x_s     = {x_raw[15], x_raw};
        y_s     = {y_raw[15], y_raw};
        // chain field (tile count minus one) times sixteen
        far_off = {{(POS_W-CHAIN_W-4){1'b0}}, chain, 4'b0000};

        o_job.code    = {tile_hi[5:0], tile_lo};
        o_job.col     = colour[COL_W-1:0];
        o_job.flip_x  = fx;
        o_job.flip_y  = fy;
        o_job.pos_x   = (!ychain && fx) ? x_s + far_off : x_s;
        o_job.pos_y   = (ychain && fy) ? y_s + far_off : y_s;
        o_job.ychain  = ychain;
        o_job.reverse = ychain ? fy : fx;
        o_job.chain   = chain;
        o_job.copy    = r_wrap_en;
    end

    assign o_tready = !i_qstat.full;
    assign o_push   = i_tvalid && o_tready && !ctrl[CTL_DISABLE];

endmodule

// ===== rtl/core/scx_queue.sv =====
// scx_queue: short job queue between the front and back parts
// register storage with head read; uses scx_pkg
module scx_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scx_pkg::t_job   i_job,
    input  logic            i_pop,
    output scx_pkg::t_job   o_job,
    output scx_pkg::t_qstat o_stat
);
    import scx_pkg::*;

    t_job                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   n_wr;
    logic [Q_PTR_W-1:0]   n_rd;
    logic [Q_CNT_W-1:0]   n_count;
    logic                 do_push;
    logic                 do_pop;

    always_comb begin
        do_push = i_push && (r_count != Q_CNT_W'(Q_DEPTH));
        do_pop  = i_pop && (r_count != '0);
        n_wr    = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd    = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            r_count <= n_count;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== rtl/core/scx_back.sv =====
// scx_back: walks one queued job tile by tile and emits placements into an output register
// main placement then optional copy 256 lines lower; uses scx_pkg
module scx_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  scx_pkg::t_job             i_job,
    input  scx_pkg::t_qstat           i_qstat,
    output logic                      o_pop,
    output logic                      o_busy,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [scx_pkg::OUT_W-1:0] o_tdata,
    output logic                      o_tlast
);
    import scx_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAIN = 3'b010,
        ST_COPY = 3'b100
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [CODE_W-1:0]       r_code;
    logic [COL_W-1:0]        r_col;
    logic                    r_fx;
    logic                    r_fy;
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;
    logic                    r_ychain;
    logic                    r_rev;
    logic [CHAIN_W-1:0]      r_left;
    logic                    r_copy;

    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;
    logic                    r_out_last;
    logic                    n_out_valid;
    logic [OUT_W-1:0]        n_out_data;
    logic                    n_out_last;

    logic                    advance;
    logic                    emit;
    logic                    next_tile;
    logic signed [POS_W-1:0] step;
    logic signed [POS_W-1:0] emit_y;

    always_comb begin
        advance     = !r_out_valid || i_tready;
        o_pop       = (r_state == ST_IDLE) && !i_qstat.empty;
        step        = r_rev ? -TILE_STEP : TILE_STEP;
        emit        = 1'b0;
        next_tile   = 1'b0;
        emit_y      = r_y;
        n_out_last  = r_out_last;
        n_state     = r_state;

        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = ST_MAIN;
                end
            end
            ST_MAIN: begin
                if (advance) begin
                    emit       = 1'b1;
                    n_out_last = (r_left == '0) && !r_copy;
                    if (r_copy) begin
                        n_state = ST_COPY;
                    end else begin
                        next_tile = 1'b1;
                    end
                end
            end
            ST_COPY: begin
                if (advance) begin
                    emit       = 1'b1;
                    emit_y     = r_y + WRAP_OFFSET;
                    n_out_last = (r_left == '0);
                    next_tile  = 1'b1;
                    n_state    = ST_MAIN;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (next_tile && (r_left == '0)) begin
            n_state = ST_IDLE;
        end

        // fields from the lowest bit: tile_code, colour_bank, flip_x, flip_y, pos_x, pos_y
        n_out_data  = {{(OUT_W-54){1'b0}}, emit_y, r_x, r_fy, r_fx, r_col, r_code};
        n_out_valid = emit ? 1'b1 : (advance ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code   <= i_job.code;
            r_col    <= i_job.col;
            r_fx     <= i_job.flip_x;
            r_fy     <= i_job.flip_y;
            r_x      <= i_job.pos_x;
            r_y      <= i_job.pos_y;
            r_ychain <= i_job.ychain;
            r_rev    <= i_job.reverse;
            r_left   <= i_job.chain;
            r_copy   <= i_job.copy;
        end else if (next_tile) begin
            r_code <= r_code + 1'b1;
            r_left <= r_left - 1'b1;
            if (r_ychain) begin
                r_y <= r_y + step;
            end else begin
                r_x <= r_x + step;
            end
        end
        if (emit) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

endmodule

// ===== rtl/core/sprite_chain_expander.sv =====
// sprite_chain_expander: top level, expands sprite attribute entries into tile placements
// instantiates scx_front, scx_queue and scx_back; uses scx_pkg
//
// channel   dir  beat content (lowest bit first)
// s_axis    in   tdata: x_raw 16, y_raw 16, control_byte 8, tile_low 8, tile_high 8, colour 8
// m_axis    out  tdata: tile_code 14, colour_bank 4, flip_x, flip_y, pos_x 17, pos_y 17, pad 2
//                tlast: final placement of the entry
// cfg       in   write enable, index (0 flipx_enable, 1 wrap_copy_enable), 1-bit data
//
// the back part emits one placement per cycle while the output is taken, and an
// entry gives (chain field + 1) placements, twice that with wrap copy; each entry is
// loaded from the two-entry job queue while idle; a disabled entry is dropped at the input
// the input keeps accepting while the queue has room, so entries overlap the back end
// reset is synchronous and active low; both config registers come up as 1
// a stall on the output holds the output register and freezes the tile walk
module sprite_chain_expander (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic                      i_cfg_wdata,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // x_raw, y_raw, control_byte, tile_low_byte, tile_high_byte, colour_byte
    input  logic [scx_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // tile_code, colour_bank, flip_x, flip_y, pos_x, pos_y, zero pad
    output logic [scx_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                      o_m_axis_tlast
);
    import scx_pkg::*;

    t_job   front_job;
    t_job   head_job;
    t_qstat q_stat;
    logic   push;
    logic   pop;
    logic   back_busy;

    // accept and classify, drop disabled entries
    scx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_tdata     (i_s_axis_tdata),
        .i_qstat     (q_stat),
        .o_push      (push),
        .o_job       (front_job)
    );

    // decouples entry intake from the tile walk
    scx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // tile walk and output register
    scx_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_qstat  (q_stat),
        .o_pop    (pop),
        .o_busy   (back_busy),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    // nothing leaves in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // a disabled entry never lands in an empty queue
    a_disabled_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata[32 + CTL_DISABLE]
         && q_stat.empty) |=> q_stat.empty)
        else $error("disabled entry queued");

    // a placement that is not the last one means the walk is still going
    a_walk_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> back_busy)
        else $error("walk ended without a last placement");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for sprite_chain_expander: streams sprite entries in and checks every tile placement
// holds its own expansion predictor, a burst driver and a stalling monitor; uses scx_pkg
module testbench;

    import scx_pkg::*;

    // entry as it sits on the input stream, x_raw in the lowest bits
    typedef struct packed {
        logic [7:0]  colour;
        logic [7:0]  tile_hi;
        logic [7:0]  tile_lo;
        logic [7:0]  ctrl;
        logic [15:0] y_raw;
        logic [15:0] x_raw;
    } t_sprite_entry;

    // placement as it sits on the output stream, tile_code in the lowest bits
    typedef struct packed {
        logic [1:0]              pad;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
        logic                    flip_y;
        logic                    flip_x;
        logic [COL_W-1:0]        colour_bank;
        logic [CODE_W-1:0]       tile_code;
    } t_placement_beat;

    typedef struct {
        t_placement_beat beat;
        logic            last;
    } t_placement;

    logic          i_clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    t_cfg_idx      cfg_index = CFG_FLIPX_EN;
    logic          cfg_wdata = 1'b0;
    logic          s_valid = 1'b0;
    t_sprite_entry s_data = '0;
    logic          m_ready = 1'b0;

    wire               o_s_axis_tready;
    wire               o_m_axis_tvalid;
    wire [OUT_W-1:0]   o_m_axis_tdata;
    wire               o_m_axis_tlast;

    // entries waiting for the driver, placements waiting for the monitor
    t_sprite_entry entry_backlog[$];
    t_placement    placement_q[$];

    // local copy of the two config registers, both 1 out of reset
    logic flipx_en_copy = 1'b1;
    logic wrap_en_copy  = 1'b1;

    int n_errors     = 0;
    int n_entries    = 0;
    int n_disabled   = 0;
    int n_placements = 0;
    int n_lasts      = 0;
    int burst_left   = 4;
    int gap_left     = 0;
    int cyc          = 0;

    logic            next_valid;
    t_sprite_entry   next_data;
    t_placement_beat seen;
    t_placement      want;

    sprite_chain_expander u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // x_raw, y_raw, control_byte, tile_low_byte, tile_high_byte, colour_byte
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // tile_code, colour_bank, flip_x, flip_y, pos_x, pos_y, zero pad
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(400000 * 4);
        $display("testbench: errors");
        $finish;
    end

    // expand one accepted entry into the placements it must give, in output order
    function automatic void expand_entry(t_sprite_entry e);
        int                px;
        int                py;
        int                dx;
        int                dy;
        int                chain;
        int                copy_y;
        logic [CODE_W-1:0] code;
        logic              fx;
        logic              fy;
        t_placement        p;
        if (e.ctrl[CTL_DISABLE]) begin
            n_disabled++;
            return;
        end
        px    = int'($signed(e.x_raw));
        py    = int'($signed(e.y_raw));
        chain = int'(e.ctrl[2:0]);
        code  = {e.tile_hi[5:0], e.tile_lo};
        fy    = e.ctrl[CTL_FLIPY];
        fx    = flipx_en_copy & e.ctrl[CTL_FLIPX];
        dx    = 0;
        dy    = 0;
        // flip along the chain axis starts at the far end and walks back;
        // a flip on the other axis only mirrors the tiles
        if (e.ctrl[CTL_YCHAIN]) begin
            if (fy) begin
                py = py + chain * 16;
                dy = -16;
            end else begin
                dy = 16;
            end
        end else begin
            if (fx) begin
                px = px + chain * 16;
                dx = -16;
            end else begin
                dx = 16;
            end
        end
        for (int i = 0; i <= chain; i++) begin
            p.beat.pad         = 2'b00;
            p.beat.tile_code   = code;
            p.beat.colour_bank = e.colour[3:0];
            p.beat.flip_x      = fx;
            p.beat.flip_y      = fy;
            p.beat.pos_x       = px[POS_W-1:0];
            p.beat.pos_y       = py[POS_W-1:0];
            p.last             = (i == chain) && !wrap_en_copy;
            placement_q.push_back(p);
            if (wrap_en_copy) begin
                // second copy 256 lines lower, carries tlast on the final tile
                copy_y       = py + 256;
                p.beat.pos_y = copy_y[POS_W-1:0];
                p.last       = (i == chain);
                placement_q.push_back(p);
            end
            code = code + 1'b1;   // wraps at 14 bits
            px   = px + dx;
            py   = py + dy;
        end
    endfunction

    function automatic t_sprite_entry make_entry(logic [15:0] x, logic [15:0] y,
                                                 logic [7:0] ctrl, logic [7:0] lo,
                                                 logic [7:0] hi, logic [7:0] col);
        t_sprite_entry e;
        e.x_raw   = x;
        e.y_raw   = y;
        e.ctrl    = ctrl;
        e.tile_lo = lo;
        e.tile_hi = hi;
        e.colour  = col;
        return e;
    endfunction

    function automatic logic [15:0] pick_coord();
        logic [15:0] corner[5] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h7f90};
        if ($urandom_range(0, 4) == 0) begin
            return corner[$urandom_range(0, 4)];
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // queue enabled entries with random content, plus some disabled ones as noise
    task automatic add_random_entries(int count);
        int            added;
        t_sprite_entry e;
        added = 0;
        while (added < count) begin
            e.x_raw   = pick_coord();
            e.y_raw   = pick_coord();
            e.ctrl    = 8'($urandom_range(0, 255));
            e.tile_lo = 8'($urandom_range(0, 255));
            e.tile_hi = 8'($urandom_range(0, 255));
            e.colour  = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) != 0) begin
                e.ctrl[CTL_DISABLE] = 1'b0;
            end
            // now and then sit just below the code wrap point
            if ($urandom_range(0, 5) == 0) begin
                e.tile_lo      = 8'($urandom_range(248, 255));
                e.tile_hi[5:0] = 6'h3f;
            end
            if (!e.ctrl[CTL_DISABLE]) begin
                added++;
            end
            entry_backlog.push_back(e);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FLIPX_EN) begin
            flipx_en_copy = val;
        end else begin
            wrap_en_copy = val;
        end
    endtask

    // waits until the backlog is sent and everything owed has come out,
    // then idles before the next setting is written
    task automatic drain();
        while (entry_backlog.size() != 0 || s_valid || placement_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (24) @(posedge i_clk);
    endtask

    // driver: bursts of random length with random gaps, prediction on each accepted beat
    always @(posedge i_clk) begin
        next_valid = s_valid;
        next_data  = s_data;
        if (rst_n && s_valid && o_s_axis_tready) begin
            expand_entry(s_data);
            n_entries++;
            next_valid = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        if (rst_n && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (entry_backlog.size() != 0) begin
                next_data  = entry_backlog.pop_front();
                next_valid = 1'b1;
            end
        end
        s_valid <= next_valid;
        s_data  <= next_data;
    end

    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
            n_errors++;
        end
    endfunction

    // monitor: compares each taken placement with the oldest one owed
    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            seen = o_m_axis_tdata;
            n_placements++;
            if (o_m_axis_tlast) begin
                n_lasts++;
            end
            if (placement_q.size() == 0) begin
                $display("%0t: unexpected placement, expected none, got %h", $time,
                         o_m_axis_tdata);
                n_errors++;
            end else begin
                want = placement_q.pop_front();
                check_field("tile_code", want.beat.tile_code, seen.tile_code);
                check_field("colour_bank", want.beat.colour_bank, seen.colour_bank);
                check_field("flip_x", want.beat.flip_x, seen.flip_x);
                check_field("flip_y", want.beat.flip_y, seen.flip_y);
                check_field("pos_x", want.beat.pos_x, seen.pos_x);
                check_field("pos_y", want.beat.pos_y, seen.pos_y);
                check_field("pad", want.beat.pad, seen.pad);
                check_field("tlast", want.last, o_m_axis_tlast);
            end
        end
        // receiver stall pattern cycles through open, random, sparse and mostly-ready
        cyc++;
        unique case (cyc[8:7])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= (cyc[2:0] == 3'd0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial begin
        logic flipx_plan[5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        logic wrap_plan[5]  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_FLIPX_EN, flipx_plan[ph]);
            write_reg(CFG_WRAP_EN, wrap_plan[ph]);
            if (ph == 0) begin
                // single tile at origin, then chains at the coordinate extremes
                entry_backlog.push_back(make_entry(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
                entry_backlog.push_back(make_entry(16'h7fff, 16'h7fff, 8'h07, 8'hfe, 8'h3f, 8'hff));
                entry_backlog.push_back(make_entry(16'h8000, 16'h8000, 8'h0f, 8'h34, 8'h12, 8'h05));
                entry_backlog.push_back(make_entry(16'hffff, 16'hffff, 8'h03, 8'hff, 8'hff, 8'hf0));
                // chains reversed along their own axis
                entry_backlog.push_back(make_entry(16'h7fff, 16'h0010, 8'h27, 8'h10, 8'h01, 8'h0a));
                entry_backlog.push_back(make_entry(16'h0020, 16'h7fff, 8'h1f, 8'h20, 8'h02, 8'h0b));
                // flip on the other axis: mirror only, order kept; then both flips together
                entry_backlog.push_back(make_entry(16'h0100, 16'h0200, 8'h2f, 8'h30, 8'h03, 8'h0c));
                entry_backlog.push_back(make_entry(16'hff00, 16'hfe00, 8'h17, 8'h40, 8'h04, 8'h0d));
                entry_backlog.push_back(make_entry(16'h8000, 16'h8000, 8'h3f, 8'hfc, 8'hff, 8'h0e));
                entry_backlog.push_back(make_entry(16'h8000, 16'h7fff, 8'h37, 8'hfa, 8'h3f, 8'h0f));
                // disabled entries give nothing; bit 6 has no effect
                entry_backlog.push_back(make_entry(16'h1234, 16'h5678, 8'h80, 8'h11, 8'h22, 8'h33));
                entry_backlog.push_back(make_entry(16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff));
                entry_backlog.push_back(make_entry(16'h0040, 16'h0050, 8'h43, 8'h55, 8'hc0, 8'h07));
                entry_backlog.push_back(make_entry(16'h0000, 16'h0000, 8'h7f, 8'hff, 8'h7f, 8'h10));
                // tile code exactly at the wrap point
                entry_backlog.push_back(make_entry(16'h0008, 16'h0009, 8'h01, 8'hff, 8'h3f, 8'h01));
                entry_backlog.push_back(make_entry(16'h0000, 16'hffff, 8'h00, 8'hff, 8'hff, 8'h0f));
            end
            // flip X on an X chain in every setting, so the forced-off case is seen
            entry_backlog.push_back(make_entry(16'h0300, 16'h0040, 8'h27, 8'h77, 8'h21, 8'h09));
            entry_backlog.push_back(make_entry(16'h8000, 16'h0040, 8'h25, 8'hfe, 8'h3f, 8'h06));
            add_random_entries(30);
            drain();
        end

        $display("covered %0d entries (%0d disabled) giving %0d placements, %0d of them last,",
                 n_entries, n_disabled, n_placements, n_lasts);
        $display("across every combination of flip X honouring and wrap copy");
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/scx_pkg.sv
rtl/core/scx_front.sv
rtl/core/scx_queue.sv
rtl/core/scx_back.sv
rtl/core/sprite_chain_expander.sv
tb/sv/testbench.sv
